// File: hw/rtl/sit_pkg.sv
`default_nettype none

package sit_pkg;

   localparam int COORD_WIDTH = 16;
   // coordinate differences, their products and sums of two products
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH = PROD_WIDTH + 1;
   localparam int REL_WIDTH = 3;

   typedef enum logic [REL_WIDTH-1:0] {
      REL_CCW = 3'd0,
      REL_CW = 3'd1,
      REL_BACK = 3'd2,
      REL_FRONT = 3'd3,
      REL_ON = 3'd4
   } rel_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } point_type;

   typedef struct packed {
      point_type a_start;
      point_type a_end;
      point_type b_start;
      point_type b_end;
   } pair_type;

   function automatic logic straddles(input rel_type r1, input rel_type r2);
      return (r1 == REL_CCW && r2 == REL_CW) || (r1 == REL_CW && r2 == REL_CCW);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sit_classify.sv
`default_nettype none

module sit_classify (
   input  sit_pkg::point_type seg_start,
   input  sit_pkg::point_type seg_end,
   input  sit_pkg::point_type pnt,
   output sit_pkg::rel_type   rel
);

   localparam int DW = sit_pkg::DIFF_WIDTH;
   localparam int PW = sit_pkg::PROD_WIDTH;
   localparam int SW = sit_pkg::SUM_WIDTH;

   logic signed [DW-1:0] bx, by, hx, hy, ux, uy, wx, wy;
   logic signed [PW-1:0] cross_l, cross_r;
   logic signed [PW-1:0] dot_x, dot_y;
   logic signed [PW-1:0] sq_ux, sq_uy, sq_wx, sq_wy;
   logic signed [SW-1:0] dot, dist_u, dist_w;

   assign bx = DW'(seg_end.x) - DW'(seg_start.x);
   assign by = DW'(seg_end.y) - DW'(seg_start.y);
   assign hx = DW'(pnt.x) - DW'(seg_start.x);
   assign hy = DW'(pnt.y) - DW'(seg_start.y);
   assign ux = DW'(seg_start.x) - DW'(pnt.x);
   assign uy = DW'(seg_start.y) - DW'(pnt.y);
   assign wx = DW'(seg_end.x) - DW'(pnt.x);
   assign wy = DW'(seg_end.y) - DW'(pnt.y);

   assign cross_l = PW'(bx) * PW'(hy);
   assign cross_r = PW'(by) * PW'(hx);
   assign dot_x = PW'(ux) * PW'(wx);
   assign dot_y = PW'(uy) * PW'(wy);
   assign sq_ux = PW'(ux) * PW'(ux);
   assign sq_uy = PW'(uy) * PW'(uy);
   assign sq_wx = PW'(wx) * PW'(wx);
   assign sq_wy = PW'(wy) * PW'(wy);

   assign dot = SW'(dot_x) + SW'(dot_y);
   assign dist_u = SW'(sq_ux) + SW'(sq_uy);
   assign dist_w = SW'(sq_wx) + SW'(sq_wy);

   always_comb begin
      if (cross_l > cross_r) begin
         rel = sit_pkg::REL_CCW;
      end else if (cross_l < cross_r) begin
         rel = sit_pkg::REL_CW;
      end else if (dot <= SW'(0)) begin
         rel = sit_pkg::REL_ON;
      end else if (dist_u > dist_w) begin
         rel = sit_pkg::REL_FRONT;
      end else begin
         rel = sit_pkg::REL_BACK;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/segment_intersection_test.sv
// Segment intersection test. Each transfer on req_ carries two segments A and B
// as 16-bit two's complement coordinates; each transfer on rsp_ returns the
// class of every endpoint against the other segment (0 ccw, 1 cw, 2 behind
// start, 3 beyond end, 4 on segment) and whether the segments touch or cross.
// All tests are exact integer arithmetic. A new pair is taken every cycle while
// req_stall is low; a result passes through the input register and then the
// result register, with the cross, dot and squared distance products of all four
// endpoint tests computed in parallel between them. Stall on rsp_ holds the result
// stage, and the input stage too when it is full; it reaches req_stall in the same
// cycle only when both stages are full.
`default_nettype none

module segment_intersection_test (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_a_start_x,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_a_start_y,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_a_end_x,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_a_end_y,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_b_start_x,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_b_start_y,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_b_end_x,
   input  logic signed [sit_pkg::COORD_WIDTH-1:0] req_b_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_intersects,
   output logic [sit_pkg::REL_WIDTH-1:0]        rsp_rel_b_start_to_a,
   output logic [sit_pkg::REL_WIDTH-1:0]        rsp_rel_b_end_to_a,
   output logic [sit_pkg::REL_WIDTH-1:0]        rsp_rel_a_start_to_b,
   output logic [sit_pkg::REL_WIDTH-1:0]        rsp_rel_a_end_to_b
);

   logic              pair_valid_ff, pair_valid_in;
   sit_pkg::pair_type pair_ff, pair_in;
   logic              out_valid_ff, out_valid_in;
   logic              hit_ff, hit_in;
   sit_pkg::rel_type  r1_ff, r2_ff, r3_ff, r4_ff;
   sit_pkg::rel_type  r1_in, r2_in, r3_in, r4_in;
   logic              out_hold, on_any;

   assign out_hold = out_valid_ff & rsp_stall;
   assign req_stall = pair_valid_ff & out_hold;

   always_comb begin
      pair_in = pair_ff;
      pair_valid_in = pair_valid_ff;
      if (!req_stall) begin
         pair_valid_in = req_valid;
         if (req_valid) begin
            pair_in.a_start = '{x: req_a_start_x, y: req_a_start_y};
            pair_in.a_end = '{x: req_a_end_x, y: req_a_end_y};
            pair_in.b_start = '{x: req_b_start_x, y: req_b_start_y};
            pair_in.b_end = '{x: req_b_end_x, y: req_b_end_y};
         end
      end
   end

   sit_classify u_b_start (
      .seg_start (pair_ff.a_start),
      .seg_end   (pair_ff.a_end),
      .pnt       (pair_ff.b_start),
      .rel       (r1_in)
   );

   sit_classify u_b_end (
      .seg_start (pair_ff.a_start),
      .seg_end   (pair_ff.a_end),
      .pnt       (pair_ff.b_end),
      .rel       (r2_in)
   );

   sit_classify u_a_start (
      .seg_start (pair_ff.b_start),
      .seg_end   (pair_ff.b_end),
      .pnt       (pair_ff.a_start),
      .rel       (r3_in)
   );

   sit_classify u_a_end (
      .seg_start (pair_ff.b_start),
      .seg_end   (pair_ff.b_end),
      .pnt       (pair_ff.a_end),
      .rel       (r4_in)
   );

   assign on_any = (r1_in == sit_pkg::REL_ON) || (r2_in == sit_pkg::REL_ON)
                || (r3_in == sit_pkg::REL_ON) || (r4_in == sit_pkg::REL_ON);
   assign hit_in = on_any
                || (sit_pkg::straddles(r1_in, r2_in) && sit_pkg::straddles(r3_in, r4_in));
   assign out_valid_in = out_hold ? out_valid_ff : pair_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         out_valid_ff <= out_valid_in;
      end
      pair_ff <= pair_in;
      // result register takes a new value whenever it is not holding a stalled transfer
      if (!out_hold) begin
         hit_ff <= hit_in;
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         r3_ff <= r3_in;
         r4_ff <= r4_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_intersects = hit_ff;
   assign rsp_rel_b_start_to_a = r1_ff;
   assign rsp_rel_b_end_to_a = r2_ff;
   assign rsp_rel_a_start_to_b = r3_ff;
   assign rsp_rel_a_end_to_b = r4_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sit_checker.sv
`default_nettype none

module sit_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_intersects,
   input logic [sit_pkg::REL_WIDTH-1:0]  rsp_rel_b_start_to_a,
   input logic [sit_pkg::REL_WIDTH-1:0]  rsp_rel_b_end_to_a,
   input logic [sit_pkg::REL_WIDTH-1:0]  rsp_rel_a_start_to_b,
   input logic [sit_pkg::REL_WIDTH-1:0]  rsp_rel_a_end_to_b
);

   logic on_any, straddle_a, straddle_b;

   assign on_any = (rsp_rel_b_start_to_a == sit_pkg::REL_ON)
                || (rsp_rel_b_end_to_a == sit_pkg::REL_ON)
                || (rsp_rel_a_start_to_b == sit_pkg::REL_ON)
                || (rsp_rel_a_end_to_b == sit_pkg::REL_ON);
   assign straddle_a = sit_pkg::straddles(sit_pkg::rel_type'(rsp_rel_b_start_to_a),
                                          sit_pkg::rel_type'(rsp_rel_b_end_to_a));
   assign straddle_b = sit_pkg::straddles(sit_pkg::rel_type'(rsp_rel_a_start_to_b),
                                          sit_pkg::rel_type'(rsp_rel_a_end_to_b));

   // a stalled result transfer stays valid and keeps its hit flag and its b-start and a-end classes
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_intersects)
         && $stable(rsp_rel_b_start_to_a) && $stable(rsp_rel_a_end_to_b))
      else $error("result changed while stalled");

   // an endpoint on the other segment always means a hit
   a_on_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && on_any |-> rsp_intersects)
      else $error("endpoint on segment but no intersection");

   // a hit without touching needs a straddle both ways
   a_hit_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_intersects && !on_any |-> straddle_a && straddle_b)
      else $error("intersection without cause");

   // input side only stalls when the result side is stalled
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_intersects       (rsp_intersects),
   .rsp_rel_b_start_to_a (rsp_rel_b_start_to_a),
   .rsp_rel_b_end_to_a   (rsp_rel_b_end_to_a),
   .rsp_rel_a_start_to_b (rsp_rel_a_start_to_b),
   .rsp_rel_a_end_to_b   (rsp_rel_a_end_to_b)
);

`default_nettype wire

// File: tb/tb_segment_intersection_test.sv
`default_nettype none

module tb_segment_intersection_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic    intersects;
      rel_type b_start;
      rel_type b_end;
      rel_type a_start;
      rel_type a_end;
   } seg_verdict_t;

   typedef enum int {
      SHAPE_FULL,
      SHAPE_CLUSTER,
      SHAPE_COLLINEAR,
      SHAPE_SHARED,
      SHAPE_TOUCH,
      SHAPE_POINT,
      SHAPE_EXTREME
   } shape_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_WIDTH-1:0] req_a_start_x = '0;
   logic signed [COORD_WIDTH-1:0] req_a_start_y = '0;
   logic signed [COORD_WIDTH-1:0] req_a_end_x = '0;
   logic signed [COORD_WIDTH-1:0] req_a_end_y = '0;
   logic signed [COORD_WIDTH-1:0] req_b_start_x = '0;
   logic signed [COORD_WIDTH-1:0] req_b_start_y = '0;
   logic signed [COORD_WIDTH-1:0] req_b_end_x = '0;
   logic signed [COORD_WIDTH-1:0] req_b_end_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_intersects;
   logic [REL_WIDTH-1:0] rsp_rel_b_start_to_a;
   logic [REL_WIDTH-1:0] rsp_rel_b_end_to_a;
   logic [REL_WIDTH-1:0] rsp_rel_a_start_to_b;
   logic [REL_WIDTH-1:0] rsp_rel_a_end_to_b;

   seg_verdict_t verdict_q[$];
   bit sender_gaps = 1'b0;
   bit receiver_gaps = 1'b0;
   int hold_request = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_hits = 0;
   int n_collinear = 0;
   int n_mismatch = 0;
   int idle_cycles = 0;

   segment_intersection_test i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_a_start_x        (req_a_start_x),
      .req_a_start_y        (req_a_start_y),
      .req_a_end_x          (req_a_end_x),
      .req_a_end_y          (req_a_end_y),
      .req_b_start_x        (req_b_start_x),
      .req_b_start_y        (req_b_start_y),
      .req_b_end_x          (req_b_end_x),
      .req_b_end_y          (req_b_end_y),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_intersects       (rsp_intersects),
      .rsp_rel_b_start_to_a (rsp_rel_b_start_to_a),
      .rsp_rel_b_end_to_a   (rsp_rel_b_end_to_a),
      .rsp_rel_a_start_to_b (rsp_rel_a_start_to_b),
      .rsp_rel_a_end_to_b   (rsp_rel_a_end_to_b)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint coord(input logic [COORD_WIDTH-1:0] v);
      return longint'(signed'(v));
   endfunction

   // side of point p relative to the directed segment s->e, or its place along it when collinear
   function automatic rel_type side_of(input point_type s, input point_type e,
                                       input point_type p);
      longint sx, sy, ex, ey, px, py;
      longint lhs, rhs, ux, uy, wx, wy;
      sx = coord(s.x);
      sy = coord(s.y);
      ex = coord(e.x);
      ey = coord(e.y);
      px = coord(p.x);
      py = coord(p.y);
      lhs = (ex - sx) * (py - sy);
      rhs = (ey - sy) * (px - sx);
      if (lhs > rhs) return REL_CCW;
      if (lhs < rhs) return REL_CW;
      ux = sx - px;
      uy = sy - py;
      wx = ex - px;
      wy = ey - py;
      // collinear: between the ends when the two vectors do not point the same way
      if (ux * wx <= -(uy * wy)) return REL_ON;
      if (ux * ux + uy * uy > wx * wx + wy * wy) return REL_FRONT;
      return REL_BACK;
   endfunction

   function automatic bit opposite_sides(input rel_type p, input rel_type q);
      return (p == REL_CCW && q == REL_CW) || (p == REL_CW && q == REL_CCW);
   endfunction

   function automatic seg_verdict_t predict_verdict(input pair_type p);
      seg_verdict_t v;
      bit touching;
      v.b_start = side_of(p.a_start, p.a_end, p.b_start);
      v.b_end = side_of(p.a_start, p.a_end, p.b_end);
      v.a_start = side_of(p.b_start, p.b_end, p.a_start);
      v.a_end = side_of(p.b_start, p.b_end, p.a_end);
      touching = v.b_start == REL_ON || v.b_end == REL_ON ||
                 v.a_start == REL_ON || v.a_end == REL_ON;
      v.intersects = touching || (opposite_sides(v.b_start, v.b_end) &&
                                  opposite_sides(v.a_start, v.a_end));
      return v;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic point_type pt(input int x, input int y);
      point_type q;
      q.x = COORD_WIDTH'(x);
      q.y = COORD_WIDTH'(y);
      return q;
   endfunction

   function automatic pair_type make_pair(input int ax0, input int ay0, input int ax1,
                                          input int ay1, input int bx0, input int by0,
                                          input int bx1, input int by1);
      pair_type p;
      p.a_start = pt(ax0, ay0);
      p.a_end = pt(ax1, ay1);
      p.b_start = pt(bx0, by0);
      p.b_end = pt(bx1, by1);
      return p;
   endfunction

   function automatic int near(input int center, input int radius);
      return center + int'($urandom_range(0, 2 * radius)) - radius;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int edge_coord();
      int picks[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      return picks[$urandom_range(0, 6)];
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      shape_t shape;
      int cx, cy, dx, dy, span, k;
      shape = shape_t'($urandom_range(0, 6));
      cx = near(0, 32000);
      cy = near(0, 32000);
      dx = near(0, 9);
      dy = near(0, 9);
      case (shape)
         SHAPE_FULL: begin
            p = make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), any_coord());
         end
         SHAPE_CLUSTER: begin
            p = make_pair(near(cx, 5), near(cy, 5), near(cx, 5), near(cy, 5),
                          near(cx, 5), near(cy, 5), near(cx, 5), near(cy, 5));
         end
         SHAPE_COLLINEAR: begin
            p = make_pair(cx + near(0, 12) * dx, cy, cx, cy, 0, 0, 0, 0);
            k = near(0, 12);
            p.a_start = pt(cx + k * dx, cy + k * dy);
            k = near(0, 12);
            p.a_end = pt(cx + k * dx, cy + k * dy);
            k = near(0, 12);
            p.b_start = pt(cx + k * dx, cy + k * dy);
            k = near(0, 12);
            p.b_end = pt(cx + k * dx, cy + k * dy);
         end
         SHAPE_SHARED: begin
            p = make_pair(near(cx, 200), near(cy, 200), near(cx, 200), near(cy, 200),
                          near(cx, 200), near(cy, 200), near(cx, 200), near(cy, 200));
            case ($urandom_range(0, 3))
               0: p.b_start = p.a_start;
               1: p.b_end = p.a_start;
               2: p.b_start = p.a_end;
               default: p.b_end = p.a_end;
            endcase
         end
         SHAPE_TOUCH: begin
            // one endpoint somewhere on the other segment, usually inside it
            span = $urandom_range(1, 12);
            k = $urandom_range(0, span);
            p = make_pair(cx, cy, cx + span * dx, cy + span * dy,
                          cx + k * dx, cy + k * dy, near(cx, 60), near(cy, 60));
            if ($urandom_range(0, 1) == 1) begin
               p = make_pair(p.b_start.x, p.b_start.y, p.b_end.x, p.b_end.y,
                             p.a_start.x, p.a_start.y, p.a_end.x, p.a_end.y);
            end
         end
         SHAPE_POINT: begin
            p = make_pair(near(cx, 4), near(cy, 4), near(cx, 4), near(cy, 4),
                          near(cx, 4), near(cy, 4), near(cx, 4), near(cy, 4));
            if ($urandom_range(0, 1) == 1) p.a_end = p.a_start;
            if ($urandom_range(0, 1) == 1) p.b_end = p.b_start;
         end
         default: begin
            p = make_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                          edge_coord(), edge_coord(), edge_coord(), edge_coord());
         end
      endcase
      return p;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_pair(input pair_type p);
      seg_verdict_t v;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_a_start_x <= p.a_start.x;
      req_a_start_y <= p.a_start.y;
      req_a_end_x <= p.a_end.x;
      req_a_end_y <= p.a_end.y;
      req_b_start_x <= p.b_start.x;
      req_b_start_y <= p.b_start.y;
      req_b_end_x <= p.b_end.x;
      req_b_end_y <= p.b_end.y;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v = predict_verdict(p);
      verdict_q.push_back(v);
      n_sent++;
      if (v.intersects) n_hits++;
      if (v.b_start >= REL_BACK || v.b_end >= REL_BACK ||
          v.a_start >= REL_BACK || v.a_end >= REL_BACK) n_collinear++;
   endtask

   // sender goes quiet until every outstanding result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   // receiver: long hold on request, otherwise random stall bursts when receiver_gaps is set
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_results
      seg_verdict_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_LIMIT)
               $display("%0t: result transfer with nothing outstanding", $realtime);
         end else begin
            want = verdict_q.pop_front();
            n_checked++;
            if (rsp_intersects !== want.intersects ||
                rsp_rel_b_start_to_a !== want.b_start ||
                rsp_rel_b_end_to_a !== want.b_end ||
                rsp_rel_a_start_to_b !== want.a_start ||
                rsp_rel_a_end_to_b !== want.a_end) begin
               n_mismatch++;
               if (n_mismatch <= REPORT_LIMIT)
                  $display("%0t: result %0d mismatch: hit/bs/be/as/ae expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                           $realtime, n_checked, want.intersects, want.b_start,
                           want.b_end, want.a_start, want.a_end, rsp_intersects,
                           rsp_rel_b_start_to_a, rsp_rel_b_end_to_a,
                           rsp_rel_a_start_to_b, rsp_rel_a_end_to_b);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      // crossing diagonals, both orientations
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
      send_pair(make_pair(10, 10, 0, 0, 10, 0, 0, 10));
      // parallel, and lines crossing outside the segments
      send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
      send_pair(make_pair(0, 0, 2, 2, 10, 0, 0, 10));
      // collinear: overlapping, all behind start, all beyond end, contained
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
      send_pair(make_pair(0, 0, 10, 0, -5, 0, -1, 0));
      send_pair(make_pair(0, 0, 10, 0, 12, 0, 20, 0));
      send_pair(make_pair(0, 0, 4, 2, -4, -2, 8, 4));
      // shared endpoint, T junction, just past the end
      send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
      send_pair(make_pair(0, 0, 10, 0, 11, 0, 11, 1));
      // degenerate segments
      send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
      send_pair(make_pair(3, 4, 3, 4, 0, 0, 6, 6));
      send_pair(make_pair(7, -7, 7, -7, 7, -7, 7, -7));
      send_pair(make_pair(7, -7, 7, -7, -7, 7, -7, 7));
      // full-range coordinates
      send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
      send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(make_pair(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
      send_pair(make_pair(-32768, 0, 32767, 0, 0, 0, -32768, 0));
      send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, 32767, -32768));
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering, so req_stall must rise
   task automatic test_backpressure();
      sender_gaps = 1'b0;
      hold_request = 64;
      repeat (24) send_pair(random_pair());
      wait_drained();
   endtask

   task automatic test_random_idling(input int count);
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      repeat (count / 2) send_pair(random_pair());
      wait_drained();
      repeat (count - count / 2) send_pair(random_pair());
      wait_drained();
   endtask

   task automatic test_random_streaming(input int count);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      repeat (count) send_pair(random_pair());
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_idling(300);
      test_random_streaming(100);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d segment pairs (directed, full-range, clustered, collinear,",
               n_sent);
      $display("touching, degenerate) with %0d results checked, %0d hits, %0d collinear",
               n_checked, n_hits, n_collinear);
      if (n_mismatch == 0 && verdict_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", n_mismatch, verdict_q.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/sit_pkg.sv
hw/rtl/sit_classify.sv
hw/rtl/segment_intersection_test.sv
hw/rtl/sit_checker.sv
tb/tb_segment_intersection_test.sv
